// ===== sv/cra_pkg.sv =====
`default_nettype none

package cra_pkg;

    // Field widths
    localparam int NC_W    = 5;   // core counts, copy counts, config values
    localparam int CORE_W  = 4;   // core index, round-robin pointer
    localparam int SID_W   = 32;  // session identifier
    localparam int CFG_IDX_W = 2;

    // Core count limits
    localparam int MAX_CORES   = 16;
    localparam int FIXED_LIMIT = 4;
    localparam int OUT_MAX     = 16;

    // Remainder unit: dividend holds pointer plus core count
    localparam int MOD_OPER_W = 6;
    localparam int MOD_STEPS  = 6;
    localparam int MOD_STEP_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CORES,
        CFG_MAX_DUP,
        CFG_FIRST_GROUP_DUP,
        CFG_READY
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOD,
        ST_EMIT,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic [SID_W-1:0]  session;
        logic [CORE_W-1:0] start;
    } slot_entry_t;

endpackage

`default_nettype wire

// ===== sv/cra_mod_unit.sv =====
`default_nettype none

// Restoring remainder: one conditional subtract of a shifted divisor per cycle.
module cra_mod_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [cra_pkg::MOD_OPER_W-1:0]     dividend,
    input  wire logic [cra_pkg::NC_W-1:0]           divisor,
    output logic                                    busy,
    output logic                                    done,
    output logic [cra_pkg::CORE_W-1:0]              remainder
);

    localparam int SH_W = cra_pkg::MOD_OPER_W + cra_pkg::NC_W;

    logic [cra_pkg::MOD_OPER_W-1:0] rem_reg, rem_next;
    logic [cra_pkg::NC_W-1:0]       div_reg, div_next;
    logic [cra_pkg::MOD_STEP_W-1:0] step_reg, step_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [SH_W-1:0]                shifted;

    always_comb begin
        shifted   = {{cra_pkg::MOD_OPER_W{1'b0}}, div_reg} << step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            div_next  = divisor;
            step_next = cra_pkg::MOD_STEP_W'(cra_pkg::MOD_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({{cra_pkg::NC_W{1'b0}}, rem_reg} >= shifted) begin
                rem_next = rem_reg - shifted[cra_pkg::MOD_OPER_W-1:0];
            end
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        step_reg <= step_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg[cra_pkg::CORE_W-1:0];

endmodule

`default_nettype wire

// ===== sv/cra_sess_mem.sv =====
`default_nettype none

// Session table: entry memory with registered read, valid bits in flops.
module cra_sess_mem #(
    parameter int SESSION_SLOTS = 16,
    localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  rd_en,
    input  wire logic [SLOT_W-1:0]     rd_addr,
    output logic                       rd_valid,
    output cra_pkg::slot_entry_t       rd_entry,
    input  wire logic                  wr_en,
    input  wire logic [SLOT_W-1:0]     wr_addr,
    input  wire cra_pkg::slot_entry_t  wr_entry
);

    cra_pkg::slot_entry_t mem [SESSION_SLOTS];
    logic [SESSION_SLOTS-1:0] valid_reg;
    cra_pkg::slot_entry_t     rd_entry_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ===== sv/core_range_allocator.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// s_        in         s_valid / s_ready       one placement request
// m_        out        m_valid / m_ready       one granted range (status, start, count, last)
// cfg_      in         cfg_valid / cfg_ready   register index and write data
//
// An error result (block not ready) is emitted from ST_EMIT. A single range without a session
// first passes the remainder unit for the pointer wrap, then ST_EMIT. A session adds a
// pipelined table scan that stops early on a hit, which leaves the pointer alone. Copy runs
// give one range per cycle while m_ready is high and no wrap is in flight; a pointer left
// out of range by a core count change costs one pass through the remainder unit. Reset clears
// the pointer and slot valid bits at once; a low m_ready stalls emission, s_ready is idle only.
module core_range_allocator #(
    parameter int SESSION_SLOTS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [cra_pkg::NC_W-1:0]      s_optimal_cores,
    input  wire logic                          s_auto_multicore,
    input  wire logic [cra_pkg::NC_W-1:0]      s_requested_cores,
    input  wire logic [cra_pkg::NC_W-1:0]      s_max_duplicates,
    input  wire logic                          s_has_session,
    input  wire logic [cra_pkg::SID_W-1:0]     s_session_id,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_status,
    output logic [cra_pkg::CORE_W-1:0]         m_start_core,
    output logic [cra_pkg::NC_W-1:0]           m_core_count,
    output logic                               m_last,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cra_pkg::NC_W-1:0]      cfg_data
);

    localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam int SCNT_W = $clog2(SESSION_SLOTS + 1);
    localparam logic [SCNT_W-1:0] SCAN_END = SCNT_W'(SESSION_SLOTS);
    localparam logic [cra_pkg::NC_W-1:0] NC_MAX = cra_pkg::NC_W'(cra_pkg::MAX_CORES);
    localparam logic [cra_pkg::NC_W-1:0] NC_FIXED = cra_pkg::NC_W'(cra_pkg::FIXED_LIMIT);
    localparam logic [cra_pkg::NC_W-1:0] NC_OUT = cra_pkg::NC_W'(cra_pkg::OUT_MAX);

    // Configuration registers
    logic [cra_pkg::NC_W-1:0] num_cores_reg;
    logic [cra_pkg::NC_W-1:0] max_dup_reg;
    logic [cra_pkg::NC_W-1:0] fgd_reg;
    logic                     ready_cfg_reg;

    // Control state
    cra_pkg::state_t              state_reg, state_next;
    logic [cra_pkg::CORE_W-1:0]   rr_reg, rr_next;
    logic [SCNT_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic                         cmp_pend_reg, cmp_pend_next;
    logic                         free_found_reg, free_found_next;
    logic                         m_valid_reg;

    // Request context
    logic [cra_pkg::NC_W-1:0]     nc_reg, nc_next;
    logic                         autom_reg, autom_next;
    logic [cra_pkg::SID_W-1:0]    sid_reg, sid_next;
    logic [cra_pkg::CORE_W-1:0]   start_reg, start_next;
    logic                         err_reg, err_next;
    logic [cra_pkg::NC_W-1:0]     copies_reg, copies_next;
    logic [cra_pkg::NC_W-1:0]     idx_reg, idx_next;
    logic                         rot_path_reg, rot_path_next;
    logic [SLOT_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0]            free_idx_reg, free_idx_next;

    // Output payload
    logic                         m_status_reg, m_status_next;
    logic [cra_pkg::CORE_W-1:0]   m_start_reg, m_start_next;
    logic [cra_pkg::NC_W-1:0]     m_count_reg, m_count_next;
    logic                         m_last_reg, m_last_next;
    logic                         load_out;
    logic                         out_free;

    // Effective core count and copy count of the incoming request
    logic [cra_pkg::NC_W-1:0]     ncores;
    logic [cra_pkg::NC_W-1:0]     copies_base, copies_dup, in_copies;
    logic                         fixed_place;
    logic [cra_pkg::NC_W-1:0]     rot_sum;

    // Remainder unit
    logic                              mod_start;
    logic [cra_pkg::MOD_OPER_W-1:0]    mod_dividend;
    logic                              mod_busy;
    logic                              mod_done;
    logic [cra_pkg::CORE_W-1:0]        mod_rem;

    // Session table
    logic                         rd_en;
    logic                         rd_valid;
    cra_pkg::slot_entry_t         rd_entry;
    logic                         wr_en;
    cra_pkg::slot_entry_t         wr_entry;

    cra_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (ncores),
        .busy      (mod_busy),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    cra_sess_mem #(
        .SESSION_SLOTS (SESSION_SLOTS)
    ) u_sess (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_ptr_reg[SLOT_W-1:0]),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (free_idx_reg),
        .wr_entry (wr_entry)
    );

    // Zero cores act as one, anything past the core limit as the limit
    always_comb begin
        if (num_cores_reg == '0) begin
            ncores = cra_pkg::NC_W'(1);
        end else if (num_cores_reg > NC_MAX) begin
            ncores = NC_MAX;
        end else begin
            ncores = num_cores_reg;
        end
        fixed_place = (ncores <= NC_FIXED);
    end

    // Copy count: requested, group count or executable limit, then clamp twice
    always_comb begin
        if (s_auto_multicore) begin
            copies_base = s_requested_cores;
        end else if (fgd_reg == '0) begin
            copies_base = (s_max_duplicates < ncores) ? s_max_duplicates : ncores;
        end else begin
            copies_base = fgd_reg;
        end
        copies_dup = (copies_base < max_dup_reg) ? copies_base : max_dup_reg;
        in_copies  = (copies_dup < NC_OUT) ? copies_dup : NC_OUT;
    end

    assign out_free = !m_valid_reg || m_ready;
    assign rot_sum  = {1'b0, rr_reg} + cra_pkg::NC_W'(1);
    assign wr_entry = '{session: sid_reg, start: rr_reg};

    always_comb begin
        state_next      = state_reg;
        rr_next         = rr_reg;
        rd_ptr_next     = rd_ptr_reg;
        cmp_pend_next   = 1'b0;
        cmp_idx_next    = rd_ptr_reg[SLOT_W-1:0];
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        nc_next         = nc_reg;
        autom_next      = autom_reg;
        sid_next        = sid_reg;
        start_next      = start_reg;
        err_next        = err_reg;
        copies_next     = copies_reg;
        idx_next        = idx_reg;
        rot_path_next   = rot_path_reg;
        m_status_next   = m_status_reg;
        m_start_next    = m_start_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        load_out        = 1'b0;
        mod_start       = 1'b0;
        mod_dividend    = '0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        s_ready         = (state_reg == cra_pkg::ST_IDLE);

        case (state_reg)
            cra_pkg::ST_IDLE: begin
                if (s_valid) begin
                    nc_next    = s_optimal_cores;
                    autom_next = s_auto_multicore;
                    sid_next   = s_session_id;
                    if (!ready_cfg_reg) begin
                        // Error result, state untouched
                        err_next   = 1'b1;
                        start_next = '0;
                        state_next = cra_pkg::ST_EMIT;
                    end else if (s_optimal_cores > cra_pkg::NC_W'(1) ||
                                 max_dup_reg == cra_pkg::NC_W'(1)) begin
                        // Single range at the pointer unless the session is known
                        err_next      = 1'b0;
                        start_next    = rr_reg;
                        rot_path_next = 1'b0;
                        if (s_has_session) begin
                            rd_ptr_next     = '0;
                            free_found_next = 1'b0;
                            state_next      = cra_pkg::ST_SCAN;
                        end else begin
                            mod_start    = 1'b1;
                            mod_dividend = cra_pkg::MOD_OPER_W'(rr_reg) +
                                           cra_pkg::MOD_OPER_W'(s_optimal_cores);
                            state_next   = cra_pkg::ST_MOD;
                        end
                    end else begin
                        // Copy run; an empty run gives no result
                        copies_next   = in_copies;
                        idx_next      = '0;
                        rot_path_next = 1'b1;
                        if (in_copies != '0) begin
                            state_next = cra_pkg::ST_COPY;
                        end
                    end
                end
            end

            cra_pkg::ST_SCAN: begin
                // Issue one read per cycle, compare the entry read last cycle
                if (rd_ptr_reg != SCAN_END) begin
                    rd_en       = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                cmp_pend_next = rd_en;
                if (cmp_pend_reg && rd_valid && rd_entry.session == sid_reg) begin
                    start_next = rd_entry.start;
                    state_next = cra_pkg::ST_EMIT;
                end else begin
                    if (cmp_pend_reg && !rd_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (!cmp_pend_reg && rd_ptr_reg == SCAN_END) begin
                        // New session: record it if a slot is free, then advance
                        wr_en        = free_found_reg;
                        mod_start    = 1'b1;
                        mod_dividend = cra_pkg::MOD_OPER_W'(rr_reg) +
                                       cra_pkg::MOD_OPER_W'(nc_reg);
                        state_next   = cra_pkg::ST_MOD;
                    end
                end
            end

            cra_pkg::ST_MOD: begin
                if (mod_done) begin
                    rr_next = mod_rem;
                    if (!rot_path_reg) begin
                        state_next = cra_pkg::ST_EMIT;
                    end else if (idx_reg == copies_reg) begin
                        state_next = cra_pkg::ST_IDLE;
                    end else begin
                        state_next = cra_pkg::ST_COPY;
                    end
                end
            end

            cra_pkg::ST_EMIT: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    m_status_next = err_reg;
                    m_start_next  = start_reg;
                    m_count_next  = err_reg ? '0 : nc_reg;
                    m_last_next   = 1'b1;
                    state_next    = cra_pkg::ST_IDLE;
                end
            end

            cra_pkg::ST_COPY: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    m_status_next = 1'b0;
                    m_start_next  = (autom_reg || fixed_place) ?
                                    idx_reg[cra_pkg::CORE_W-1:0] : rr_reg;
                    m_count_next  = autom_reg ? cra_pkg::NC_W'(1) : nc_reg;
                    m_last_next   = (idx_reg + 1'b1 == copies_reg);
                    idx_next      = idx_reg + 1'b1;
                    if (!autom_reg && !fixed_place) begin
                        // Rotate by one; a pointer past the range needs the full wrap
                        if (rot_sum < ncores) begin
                            rr_next = rot_sum[cra_pkg::CORE_W-1:0];
                        end else if (rot_sum == ncores) begin
                            rr_next = '0;
                        end else begin
                            mod_start    = 1'b1;
                            mod_dividend = cra_pkg::MOD_OPER_W'(rot_sum);
                        end
                    end
                    if (mod_start) begin
                        state_next = cra_pkg::ST_MOD;
                    end else if (m_last_next) begin
                        state_next = cra_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = cra_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cra_pkg::ST_IDLE;
            rr_reg         <= '0;
            rd_ptr_reg     <= '0;
            cmp_pend_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rr_reg         <= rr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cmp_pend_reg   <= cmp_pend_next;
            free_found_reg <= free_found_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request context and output payload
    always_ff @(posedge aclk) begin
        nc_reg        <= nc_next;
        autom_reg     <= autom_next;
        sid_reg       <= sid_next;
        start_reg     <= start_next;
        err_reg       <= err_next;
        copies_reg    <= copies_next;
        idx_reg       <= idx_next;
        rot_path_reg  <= rot_path_next;
        cmp_idx_reg   <= cmp_idx_next;
        free_idx_reg  <= free_idx_next;
        m_status_reg  <= m_status_next;
        m_start_reg   <= m_start_next;
        m_count_reg   <= m_count_next;
        m_last_reg    <= m_last_next;
    end

    // Configuration writes; always accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cores_reg <= cra_pkg::NC_W'(1);
            max_dup_reg   <= cra_pkg::NC_W'(16);
            fgd_reg       <= '0;
            ready_cfg_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cra_pkg::cfg_idx_t'(cfg_index))
                cra_pkg::CFG_NUM_CORES:       num_cores_reg <= cfg_data;
                cra_pkg::CFG_MAX_DUP:         max_dup_reg   <= cfg_data;
                cra_pkg::CFG_FIRST_GROUP_DUP: fgd_reg       <= cfg_data;
                cra_pkg::CFG_READY:           ready_cfg_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_start_core = m_start_reg;
    assign m_core_count = m_count_reg;
    assign m_last       = m_last_reg;

`ifndef NO_ASSERTIONS
    // The wrapped pointer always lands inside the effective core range
    a_mod_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> ({1'b0, mod_rem} < ncores))
        else $error("remainder not below core count");

    // An error result is a lone, empty range
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_last && m_core_count == '0))
        else $error("error result with range or without last");

    // No new request is taken while the pointer wrap is still in flight
    a_idle_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mod_busy)
        else $error("request accepted during pointer wrap");

    // A table write only follows a completed scan with a free slot
    a_wr_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (free_found_reg && rd_ptr_reg == SCAN_END && !cmp_pend_reg))
        else $error("session table write outside scan end");
`endif

endmodule

`default_nettype wire
